FILE: hdl/esr_pkg.sv
package esr_pkg;

	// Table geometry
	localparam int SIGNALS    = 64;
	localparam int SLOTS      = 16;
	localparam int AGENT_BITS = 8;
	localparam int ROW_W      = (SIGNALS > 1) ? $clog2(SIGNALS) : 1;

	// Configuration register widths and indexes
	localparam int SIG_CNT_W  = 7;
	localparam int SLOT_CNT_W = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;
	localparam logic [CFG_IDX_W-1:0] REG_SIGNALS_IN_USE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE   = 1'd1;
	localparam logic [SIG_CNT_W-1:0]  SIGNALS_IN_USE_RST = 7'd64;
	localparam logic [SLOT_CNT_W-1:0] SLOTS_IN_USE_RST   = 5'd0;

	// Command queue between front and back
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		CMD_SUBSCRIBE   = 2'd0,
		CMD_UNSUBSCRIBE = 2'd1,
		CMD_PUBLISH     = 2'd2,
		CMD_UNUSED      = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK          = 2'd0,
		STAT_ALREADY     = 2'd1,
		STAT_ROW_FULL    = 2'd2,
		STAT_OUT_OF_RANGE = 2'd3
	} status_t;

	localparam logic KIND_STATUS   = 1'b0;
	localparam logic KIND_DELIVERY = 1'b1;

	// Work classified by the front
	typedef enum logic [1:0] {
		OP_SUB    = 2'd0,
		OP_UNSUB  = 2'd1,
		OP_PUB    = 2'd2,
		OP_REJECT = 2'd3
	} op_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [5:0]  signal_id;
		logic [7:0]  agent_id;
		logic [15:0] event_handle;
		logic [9:0]  event_size;
	} req_t;

	typedef struct packed {
		logic        kind;
		status_t     status;
		logic [7:0]  target_agent;
		logic [15:0] out_handle;
		logic [9:0]  out_size;
		logic        last;
	} rsp_t;

	typedef struct packed {
		op_t                   op;
		logic [ROW_W-1:0]      row;
		logic [AGENT_BITS-1:0] agent;
		logic [15:0]           handle;
		logic [9:0]            size;
	} op_entry_t;

	// Queue head towards the back
	typedef struct packed {
		logic      valid;
		op_entry_t entry;
	} q_head_t;

	// One table row: a valid bit and an agent per slot
	typedef struct packed {
		logic [SLOTS-1:0]                 valid;
		logic [SLOTS-1:0][AGENT_BITS-1:0] agent;
	} row_t;

endpackage

FILE: hdl/esr_front.sv
module esr_front import esr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  req_t                 request,
	input  logic [SIG_CNT_W-1:0] signals_in_use,
	output q_head_t              head,
	input  logic                 pop
);

	op_entry_t         q_mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              accept;
	logic              push;
	logic              in_range;
	op_entry_t         entry;

	assign busy   = (count_q == QCNT_W'(QDEPTH));
	assign accept = start && !busy;

	// Classify the request: unused code is dropped, other commands out of range are rejected
	always_comb begin
		in_range     = (SIG_CNT_W'(request.signal_id) < signals_in_use) &&
		               (int'(request.signal_id) < SIGNALS);
		entry.row    = ROW_W'(request.signal_id);
		entry.agent  = request.agent_id[AGENT_BITS-1:0];
		entry.handle = request.event_handle;
		entry.size   = request.event_size;
		push         = accept;
		unique case (request.cmd)
			CMD_SUBSCRIBE:   entry.op = OP_SUB;
			CMD_UNSUBSCRIBE: entry.op = OP_UNSUB;
			CMD_PUBLISH:     entry.op = OP_PUB;
			default: begin
				entry.op = OP_REJECT;
				push     = 1'b0;
			end
		endcase
		if (!in_range) begin
			entry.op = OP_REJECT;
		end
	end

	// Hold classified requests until the back takes them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				q_mem_q[wr_ptr_q] <= entry;
				wr_ptr_q          <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head.valid = (count_q != '0);
	assign head.entry = q_mem_q[rd_ptr_q];

endmodule

FILE: hdl/esr_back.sv
module esr_back import esr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  q_head_t               head,
	output logic                  pop,
	input  logic [SLOT_CNT_W-1:0] nslots,
	output rsp_t                  result,
	output logic                  result_strobe
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DLV
	} state_t;

	state_t           state_q;
	op_entry_t        op_q;
	logic [SLOTS-1:0] pend_q;
	logic [SIGNALS-1:0] row_valid_q;
	logic             rowv_q;
	row_t             rdata_q;
	row_t             table_mem [SIGNALS];
	rsp_t             result_q;
	logic             strobe_q;

	logic             mem_re;
	logic             mem_we;
	row_t             wr_row;
	logic [SLOTS-1:0] slot_mask;
	logic [SLOTS-1:0] valid_eff;
	logic [SLOTS-1:0] live;
	logic [SLOTS-1:0] hit;
	logic [SLOTS-1:0] free;
	logic [SLOTS-1:0] free_pick;
	logic [SLOTS-1:0] dlv_pick;
	logic [SLOTS-1:0] pend_next;
	logic [AGENT_BITS-1:0] dlv_agent;

	assign pop    = (state_q == ST_IDLE) && head.valid;
	assign mem_re = pop && (head.entry.op != OP_REJECT);

	// Decode the row that was read
	always_comb begin
		valid_eff = rowv_q ? rdata_q.valid : '0;
		for (int s = 0; s < SLOTS; s++) begin
			slot_mask[s] = (s < int'(nslots));
			hit[s]       = valid_eff[s] && slot_mask[s] &&
			               (rdata_q.agent[s] == op_q.agent);
		end
		live      = valid_eff & slot_mask;
		free      = ~valid_eff & slot_mask;
		free_pick = free & (~free + 1'b1);
	end

	// Build the row to write back
	always_comb begin
		wr_row = rdata_q;
		mem_we = 1'b0;
		if (op_q.op == OP_SUB) begin
			wr_row.valid = valid_eff | free_pick;
			for (int s = 0; s < SLOTS; s++) begin
				if (free_pick[s]) begin
					wr_row.agent[s] = op_q.agent;
				end
			end
			mem_we = (state_q == ST_EXEC) && !(|hit) && (|free);
		end else begin
			wr_row.valid = valid_eff & ~hit;
			mem_we = (state_q == ST_EXEC) && (op_q.op == OP_UNSUB) && (|hit);
		end
	end

	// Pick the next delivery in slot order
	always_comb begin
		dlv_pick  = pend_q & (~pend_q + 1'b1);
		pend_next = pend_q & ~dlv_pick;
		dlv_agent = '0;
		for (int s = 0; s < SLOTS; s++) begin
			dlv_agent = dlv_agent | (dlv_pick[s] ? rdata_q.agent[s] : '0);
		end
	end

	// Subscription table
	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[op_q.row] <= wr_row;
		end
		if (mem_re) begin
			rdata_q <= table_mem[head.entry.row];
		end
	end

	// Sequence each request and register the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= '0;
			pend_q      <= '0;
			row_valid_q <= '0;
			rowv_q      <= 1'b0;
			result_q    <= '0;
			strobe_q    <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			result_q <= '0;
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						op_q   <= head.entry;
						rowv_q <= row_valid_q[head.entry.row];
						if (head.entry.op == OP_REJECT) begin
							result_q.kind   <= KIND_STATUS;
							result_q.status <= STAT_OUT_OF_RANGE;
							result_q.last   <= 1'b1;
							strobe_q        <= 1'b1;
						end else begin
							state_q <= ST_EXEC;
						end
					end
				end
				ST_EXEC: begin
					if (mem_we) begin
						row_valid_q[op_q.row] <= 1'b1;
					end
					state_q <= ST_IDLE;
					case (op_q.op)
						OP_SUB: begin
							result_q.kind <= KIND_STATUS;
							result_q.last <= 1'b1;
							strobe_q      <= 1'b1;
							if (|hit) begin
								result_q.status <= STAT_ALREADY;
							end else if (|free) begin
								result_q.status <= STAT_OK;
							end else begin
								result_q.status <= STAT_ROW_FULL;
							end
						end
						OP_UNSUB: begin
							result_q.kind   <= KIND_STATUS;
							result_q.status <= STAT_OK;
							result_q.last   <= 1'b1;
							strobe_q        <= 1'b1;
						end
						default: begin
							pend_q <= live;
							if (|live) begin
								state_q <= ST_DLV;
							end
						end
					endcase
				end
				ST_DLV: begin
					result_q.kind         <= KIND_DELIVERY;
					result_q.status       <= STAT_OK;
					result_q.target_agent <= 8'(dlv_agent);
					result_q.out_handle   <= op_q.handle;
					result_q.out_size     <= op_q.size;
					result_q.last         <= (pend_next == '0);
					strobe_q              <= 1'b1;
					pend_q                <= pend_next;
					if (pend_next == '0) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result        = result_q;
	assign result_strobe = strobe_q;

endmodule

FILE: hdl/event_subscription_router_unit.sv
// Publish/subscribe multicast table: one row per signal, SLOTS agent slots a row,
// cleared at reset with no clearing pass. A request is taken when start is high
// and busy is low; a two-entry queue sits between the classifying front and the
// table sequencer, so busy rises only when that queue is full. Results appear on
// result for exactly one cycle, marked by result_strobe, and cannot be held off.
// Subscribe and unsubscribe requests give one status result after the sequencer
// reads the row, then updates it; an out-of-range request gives it without a
// row read. A publish reads its row through the single table read port, then
// gives one delivery per occupied slot, up to SLOTS, in the one-per-cycle
// delivery walk. A publish with no subscriber and command code 3 give no result.
module event_subscription_router_unit import esr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  req_t                  request,
	output rsp_t                  result,
	output logic                  result_strobe,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [SIG_CNT_W-1:0]  signals_in_use_q;
	logic [SLOT_CNT_W-1:0] slots_in_use_q;
	logic [SLOT_CNT_W-1:0] nslots;
	q_head_t               head;
	logic                  pop;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signals_in_use_q <= SIGNALS_IN_USE_RST;
			slots_in_use_q   <= SLOTS_IN_USE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SIGNALS_IN_USE: signals_in_use_q <= cfg_data[SIG_CNT_W-1:0];
				REG_SLOTS_IN_USE:   slots_in_use_q   <= cfg_data[SLOT_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the slot count to the table width
	assign nslots = (int'(slots_in_use_q) > SLOTS) ? SLOT_CNT_W'(SLOTS) : slots_in_use_q;

	esr_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.request        (request),
		.signals_in_use (signals_in_use_q),
		.head           (head),
		.pop            (pop)
	);

	esr_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.nslots        (nslots),
		.result        (result),
		.result_strobe (result_strobe)
	);

endmodule

FILE: bench/tb_event_subscription_router_unit.sv
module tb_event_subscription_router_unit import esr_pkg::*; ();

	localparam int CLK_PERIOD     = 20;
	localparam int SETTLE_CYCLES  = 48;
	localparam int DRAIN_LIMIT    = 2000;
	localparam int PHASE_REQUESTS = 28;

	// Subscription table mirror, expected results and result checking
	class subscription_scoreboard;
		bit                    row_valid [SIGNALS][SLOTS];
		logic [AGENT_BITS-1:0] row_agent [SIGNALS][SLOTS];
		logic [SIG_CNT_W-1:0]  signals_in_use;
		logic [SLOT_CNT_W-1:0] slots_in_use;
		rsp_t                  pending_results [$];
		int                    errors;
		int                    requests;
		int                    results;
		int                    deliveries;

		function new();
			for (int i = 0; i < SIGNALS; i++) begin
				for (int j = 0; j < SLOTS; j++) begin
					row_valid[i][j] = 1'b0;
					row_agent[i][j] = '0;
				end
			end
			signals_in_use = SIGNALS_IN_USE_RST;
			slots_in_use   = SLOTS_IN_USE_RST;
			errors     = 0;
			requests   = 0;
			results    = 0;
			deliveries = 0;
		endfunction

		function void note_register(input logic [CFG_IDX_W-1:0] idx,
				input logic [CFG_DATA_W-1:0] data);
			if (idx == REG_SIGNALS_IN_USE)
				signals_in_use = data[SIG_CNT_W-1:0];
			else if (idx == REG_SLOTS_IN_USE)
				slots_in_use = data[SLOT_CNT_W-1:0];
		endfunction

		// Apply one accepted request to the mirror and queue what it yields
		function void note_request(input req_t r);
			int                    rows;
			int                    slots;
			int                    row;
			int                    free_slot;
			int                    last_slot;
			bit                    present;
			logic [AGENT_BITS-1:0] agent;
			rsp_t                  reply;
			rows  = (int'(signals_in_use) > SIGNALS) ? SIGNALS : int'(signals_in_use);
			slots = (int'(slots_in_use) > SLOTS) ? SLOTS : int'(slots_in_use);
			row   = int'(r.signal_id);
			agent = r.agent_id[AGENT_BITS-1:0];
			reply        = '0;
			reply.kind   = KIND_STATUS;
			reply.status = STAT_OK;
			reply.last   = 1'b1;
			if (r.cmd == CMD_UNUSED)
				return;
			requests++;
			// refuse rows beyond the range in use, for all three used commands
			if (row >= rows || row >= SIGNALS) begin
				reply.status = STAT_OUT_OF_RANGE;
				pending_results.push_back(reply);
				return;
			end
			case (r.cmd)
				CMD_SUBSCRIBE: begin
					present   = 1'b0;
					free_slot = -1;
					for (int s = 0; s < slots; s++) begin
						if (row_valid[row][s] && row_agent[row][s] == agent)
							present = 1'b1;
						if (!row_valid[row][s] && free_slot < 0)
							free_slot = s;
					end
					if (present) begin
						reply.status = STAT_ALREADY;
					end else if (free_slot >= 0) begin
						row_valid[row][free_slot] = 1'b1;
						row_agent[row][free_slot] = agent;
					end else begin
						reply.status = STAT_ROW_FULL;
					end
					pending_results.push_back(reply);
				end
				CMD_UNSUBSCRIBE: begin
					for (int s = 0; s < slots; s++) begin
						if (row_valid[row][s] && row_agent[row][s] == agent) begin
							row_valid[row][s] = 1'b0;
							row_agent[row][s] = '0;
						end
					end
					pending_results.push_back(reply);
				end
				default: begin
					// one delivery per occupied slot, last on the final one
					last_slot = -1;
					for (int s = 0; s < slots; s++)
						if (row_valid[row][s])
							last_slot = s;
					for (int s = 0; s < slots; s++) begin
						if (row_valid[row][s]) begin
							reply              = '0;
							reply.kind         = KIND_DELIVERY;
							reply.status       = STAT_OK;
							reply.target_agent = 8'(row_agent[row][s]);
							reply.out_handle   = r.event_handle;
							reply.out_size     = r.event_size;
							reply.last         = (s == last_slot);
							pending_results.push_back(reply);
						end
					end
				end
			endcase
		endfunction

		function void compare_field(input string name, input logic [15:0] want,
				input logic [15:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			end
		endfunction

		// Match a result against the oldest expectation
		function void check_result(input rsp_t got);
			rsp_t want;
			results++;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				return;
			end
			want = pending_results.pop_front();
			if (want.kind == KIND_DELIVERY)
				deliveries++;
			compare_field("kind", 16'(want.kind), 16'(got.kind));
			compare_field("status", 16'(want.status), 16'(got.status));
			compare_field("target_agent", 16'(want.target_agent), 16'(got.target_agent));
			compare_field("out_handle", want.out_handle, got.out_handle);
			compare_field("out_size", 16'(want.out_size), 16'(got.out_size));
			compare_field("last", 16'(want.last), 16'(got.last));
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	req_t                  request = '0;
	rsp_t                  result;
	logic                  result_strobe;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	subscription_scoreboard board;
	int                     cur_signals;
	int                     settings_used;

	event_subscription_router_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.request       (request),
		.result        (result),
		.result_strobe (result_strobe),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Check results first, then note the request and register writes of this edge
	always @(posedge clk) begin
		if (arst_n && result_strobe !== 1'b0)
			board.check_result(result);
		if (start && !busy)
			board.note_request(request);
		if (cfg_we)
			board.note_register(cfg_index, cfg_data);
	end

	// Hold the request until the block takes it
	task automatic send_request(input req_t r, input int gap);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start   <= 1'b1;
		request <= r;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
	endtask

	task automatic send_fields(input cmd_t c, input int sig, input int agent,
			input int handle, input int size);
		req_t r;
		r.cmd          = c;
		r.signal_id    = 6'(sig);
		r.agent_id     = 8'(agent);
		r.event_handle = 16'(handle);
		r.event_size   = 10'(size);
		send_request(r, $urandom_range(0, 10));
	endtask

	// Drop start, wait for every expected result, then let silent work finish
	task automatic settle();
		int waited;
		waited = 0;
		@(negedge clk);
		start <= 1'b0;
		while (board.pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] signals,
			input logic [CFG_DATA_W-1:0] slots);
		settle();
		write_register(REG_SIGNALS_IN_USE, signals);
		write_register(REG_SLOTS_IN_USE, slots);
		cur_signals = (int'(signals) > SIGNALS) ? SIGNALS : int'(signals);
		settings_used++;
	endtask

	// Mostly commands on a few hot rows with a small agent pool, some noise
	function automatic req_t random_request(input int rows, input int hot);
		req_t r;
		int   pick;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			r.cmd = CMD_SUBSCRIBE;
		else if (pick < 60)
			r.cmd = CMD_UNSUBSCRIBE;
		else if (pick < 94)
			r.cmd = CMD_PUBLISH;
		else
			r.cmd = CMD_UNUSED;
		if (rows == 0 || $urandom_range(0, 9) == 0)
			r.signal_id = 6'($urandom_range(0, 63));
		else
			r.signal_id = 6'((hot + $urandom_range(0, 1)) % rows);
		if ($urandom_range(0, 3) == 0)
			r.agent_id = 8'($urandom_range(0, 255));
		else
			r.agent_id = 8'($urandom_range(0, 19) * 13);
		r.event_handle = 16'($urandom);
		r.event_size   = 10'($urandom);
		return r;
	endfunction

	initial begin
		req_t r;
		int   counted;
		int   n;
		int   hot;
		board = new();
		cur_signals   = SIGNALS;
		settings_used = 1;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: no slots in use
		send_fields(CMD_SUBSCRIBE, 0, 0, 0, 0);
		send_fields(CMD_UNSUBSCRIBE, 63, 255, 0, 0);
		send_fields(CMD_PUBLISH, 0, 0, 16'hFFFF, 10'h3FF);
		send_fields(CMD_UNUSED, 63, 255, 16'hFFFF, 10'h3FF);

		// Small table: fill a row, duplicate, overflow, range edge, publish
		configure(7'd8, 7'd3);
		send_fields(CMD_SUBSCRIBE, 7, 0, 0, 0);
		send_fields(CMD_SUBSCRIBE, 7, 255, 0, 0);
		send_fields(CMD_SUBSCRIBE, 7, 0, 0, 0);
		send_fields(CMD_SUBSCRIBE, 7, 9, 0, 0);
		send_fields(CMD_SUBSCRIBE, 7, 10, 0, 0);
		send_fields(CMD_PUBLISH, 7, 0, 16'hFFFF, 10'h3FF);
		send_fields(CMD_SUBSCRIBE, 8, 1, 0, 0);
		send_fields(CMD_PUBLISH, 63, 0, 16'h1234, 10'h155);
		send_fields(CMD_UNSUBSCRIBE, 63, 0, 0, 0);
		send_fields(CMD_UNSUBSCRIBE, 7, 255, 0, 0);
		send_fields(CMD_PUBLISH, 7, 255, 0, 0);
		send_fields(CMD_PUBLISH, 0, 0, 16'hABCD, 10'h2AA);
		send_fields(CMD_UNUSED, 7, 9, 0, 0);

		// No rows accepted, slot count beyond the table
		configure(7'd0, 7'd31);
		send_fields(CMD_SUBSCRIBE, 0, 3, 0, 0);
		send_fields(CMD_PUBLISH, 0, 0, 16'h0F0F, 10'h0F0);

		// Row count beyond the table, all slots
		configure(7'd127, 7'd16);
		send_fields(CMD_SUBSCRIBE, 63, 8'hAA, 0, 0);
		send_fields(CMD_SUBSCRIBE, 63, 8'h55, 0, 0);
		send_fields(CMD_PUBLISH, 63, 0, 16'h5A5A, 10'h2A5);
		send_fields(CMD_SUBSCRIBE, 7, 255, 0, 0);
		send_fields(CMD_PUBLISH, 7, 0, 16'hA5A5, 10'h15A);

		// Random phases over several register settings
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: configure(7'd64, 7'd16);
				1: configure(7'd1, 7'd1);
				2: configure(7'($urandom_range(1, 127)), 7'($urandom_range(0, 127)));
				3: configure(7'd127, 7'($urandom_range(2, 6)));
				4: configure(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
				default: configure(7'd64, 7'd16);
			endcase
			hot     = $urandom_range(0, 63);
			counted = 0;
			n       = 0;
			while (counted < PHASE_REQUESTS) begin
				r = random_request(cur_signals, hot);
				if (r.cmd != CMD_UNUSED)
					counted++;
				// every third stretch of eight requests runs without gaps
				send_request(r, ((n / 8) % 3 == 2) ? 0 : int'($urandom_range(0, 10)));
				n++;
			end
		end

		settle();
		if (board.pending_results.size() != 0) begin
			board.errors++;
			$display("%0t: %0d results never arrived, expected next %h, actual none",
				$time, board.pending_results.size(), board.pending_results[0]);
		end
		$display("covered %0d requests over %0d register settings", board.requests,
			settings_used);
		$display("checked %0d results, %0d of them deliveries", board.results,
			board.deliveries);
		if (board.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#(CLK_PERIOD * 400000);
		$display("simulation failed");
		$finish;
	end

endmodule
